@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hbs_pkg.sv @@
// Package: widths, reset constants, opcodes and sequencer states of the bitset block.
`default_nettype none

package hbs_pkg;

  localparam int WORD_BITS  = 64;
  localparam int LEAF_WORDS = 64;
  localparam int IDX_W      = 12;
  localparam int OPCODE_W   = 3;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(LEAF_WORDS);

  localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(4094);
  localparam logic [IDX_W-1:0] SIZE_LIMIT = IDX_W'(WORD_BITS * LEAF_WORDS - 2);
  localparam logic [IDX_W-1:0] SENT_RESET = IDX_W'(4094 + 1);
  localparam logic [LEAF_WORDS-1:0] SUMMARY_RESET =
    LEAF_WORDS'(1) | (LEAF_WORDS'(1) << (SENT_RESET / WORD_BITS));

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_ERASE     = 3'd1,
    OP_CONTAINS  = 3'd2,
    OP_FIND_NEXT = 3'd3,
    OP_FIND_PREV = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAF,
    S_SUM,
    S_LEAF2,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

@@ sv/hbs_if.sv @@
// Interfaces: request, response and size configuration channels.
`default_nettype none

interface hbs_req_if;
  logic                          valid;
  logic                          ready;
  logic [hbs_pkg::OPCODE_W-1:0]  opcode;
  logic [hbs_pkg::IDX_W-1:0]     index;
  modport source (output valid, opcode, index, input ready);
  modport sink (input valid, opcode, index, output ready);
endinterface

interface hbs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [hbs_pkg::IDX_W-1:0]  position;
  logic                       bad_index;
  modport source (output valid, hit, position, bad_index, input ready);
  modport sink (input valid, hit, position, bad_index, output ready);
endinterface

interface hbs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hbs_pkg::IDX_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/hbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbs_ram #(
  parameter int DataWidth = 64,
  parameter int Depth     = 64,
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/hierarchical_bitset_successor.sv @@
// Sequencing: insert/erase/contains pass S_LEAF then S_DONE; searches may add S_SUM and S_LEAF2;
// clear and rejected requests go straight to S_DONE. The result is registered out of S_DONE,
// and the next accept waits for S_IDLE, longer while an earlier result is still held.
// One request at a time; a single leaf-word RAM read port and one shared priority
// encoder set the steps (leaf read, summary search, second leaf read).
// Reset: async, active low; tree reads as cleared for size 4094 via per-word valid bits.
`default_nettype none
`include "assert_macros.svh"

module hierarchical_bitset_successor (
  input logic        clk_i,
  input logic        rst_ni,
  hbs_req_if.sink    req_i,
  hbs_rsp_if.source  rsp_o,
  hbs_cfg_if.sink    cfg_i
);
  import hbs_pkg::*;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       size_q, n_eff;
  logic [IDX_W-1:0]       sent_q, sent_d, sent_new;
  logic [OPCODE_W-1:0]    op_q, op_d;
  logic [WADDR_W-1:0]     w_q, w_d, rd_w_q, rd_w_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic [LEAF_WORDS-1:0]  summary_q, summary_d, valid_q, valid_d;
  logic                   res_hit_q, res_hit_d, res_bad_q, res_bad_d;
  logic [IDX_W-1:0]       res_pos_q, res_pos_d;
  logic                   out_valid_q, out_valid_d, out_hit_q, out_bad_q;
  logic [IDX_W-1:0]       out_pos_q;
  logic                   out_load, accept, req_bad;
  logic [IDX_W-1:0]       req_b;

  logic                   ram_we;
  logic [WADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;
  logic [WORD_BITS-1:0]   dflt_word, leaf_word, bit_mask, hi_mask, lo_mask;
  logic [LEAF_WORDS-1:0]  sum_above, sum_below;

  logic                   enc_rev, enc_hit;
  logic [WORD_BITS-1:0]   enc_in, enc_opr, enc_lsb;
  logic [OFF_W-1:0]       enc_raw, enc_idx;

  logic [IDX_W-1:0]       srch_r, srch_pos;
  logic                   srch_ok;

  assign n_eff    = (size_q > SIZE_LIMIT) ? SIZE_LIMIT : size_q;
  assign sent_new = n_eff + IDX_W'(1);
  assign req_b    = req_i.index + IDX_W'(1);
  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    case (req_i.opcode) inside
      OP_INSERT, OP_ERASE, OP_CONTAINS, OP_FIND_PREV: req_bad = (req_i.index >= n_eff);
      OP_FIND_NEXT: req_bad = (req_i.index > n_eff);
      OP_CLEAR:     req_bad = 1'b0;
      default:      req_bad = 1'b1;
    endcase
  end

  hbs_ram #(
    .DataWidth (WORD_BITS),
    .Depth     (LEAF_WORDS)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // words not written since the last clear read as their sentinel pattern
  always_comb begin
    dflt_word = '0;
    if (rd_w_q == '0) begin
      dflt_word[0] = 1'b1;
    end
    if (rd_w_q == sent_q[IDX_W-1:OFF_W]) begin
      dflt_word[sent_q[OFF_W-1:0]] = 1'b1;
    end
    leaf_word = valid_q[rd_w_q] ? ram_rdata : dflt_word;
  end

  assign bit_mask  = WORD_BITS'(1) << off_q;
  assign hi_mask   = {WORD_BITS{1'b1}} << off_q;
  assign lo_mask   = {WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - off_q);
  assign sum_above = ({LEAF_WORDS{1'b1}} << w_q) << 1;
  assign sum_below = ~({LEAF_WORDS{1'b1}} << w_q);

  // shared priority encoder: lowest set bit, or highest when searching down
  assign enc_rev = (op_q == OP_FIND_PREV);

  always_comb begin
    case (state_q)
      S_LEAF:  enc_in = leaf_word & (enc_rev ? lo_mask : hi_mask);
      S_SUM:   enc_in = summary_q & (enc_rev ? sum_below : sum_above);
      default: enc_in = leaf_word;
    endcase
    for (int k = 0; k < WORD_BITS; k++) begin
      enc_opr[k] = enc_rev ? enc_in[WORD_BITS-1-k] : enc_in[k];
    end
    enc_lsb = enc_opr & (~enc_opr + WORD_BITS'(1));
    enc_raw = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (enc_lsb[k]) begin
        enc_raw = enc_raw | OFF_W'(k);
      end
    end
    enc_idx = enc_rev ? ~enc_raw : enc_raw;
    enc_hit = |enc_opr;
  end

  assign srch_r   = (state_q == S_LEAF) ? {w_q, enc_idx} : {rd_w_q, enc_idx};
  assign srch_pos = srch_r - IDX_W'(1);
  assign srch_ok  = enc_hit && (enc_rev ? (srch_r != '0) : (srch_pos < n_eff));

  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (req_bad || req_i.opcode == OP_CLEAR) ? S_DONE : S_LEAF;
        end
      end
      S_LEAF: begin
        if ((op_q == OP_FIND_NEXT || op_q == OP_FIND_PREV) && !enc_hit) begin
          state_d = S_SUM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SUM:   state_d = enc_hit ? S_LEAF2 : S_DONE;
      S_LEAF2: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    w_d       = w_q;
    off_d     = off_q;
    rd_w_d    = rd_w_q;
    summary_d = summary_q;
    valid_d   = valid_q;
    sent_d    = sent_q;
    res_hit_d = res_hit_q;
    res_bad_d = res_bad_q;
    res_pos_d = res_pos_q;
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = leaf_word;
    ram_raddr = rd_w_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = req_i.opcode;
          w_d       = req_b[IDX_W-1:OFF_W];
          off_d     = req_b[OFF_W-1:0];
          rd_w_d    = req_b[IDX_W-1:OFF_W];
          ram_raddr = req_b[IDX_W-1:OFF_W];
          res_hit_d = 1'b0;
          res_bad_d = req_bad;
          res_pos_d = req_i.index;
          if (!req_bad && req_i.opcode == OP_CLEAR) begin
            valid_d   = '0;
            sent_d    = sent_new;
            summary_d = LEAF_WORDS'(1) | (LEAF_WORDS'(1) << sent_new[IDX_W-1:OFF_W]);
          end
        end
      end
      S_LEAF: begin
        case (op_q)
          OP_INSERT: begin
            ram_we         = 1'b1;
            ram_wdata      = leaf_word | bit_mask;
            valid_d[w_q]   = 1'b1;
            summary_d[w_q] = 1'b1;
            res_hit_d      = !leaf_word[off_q];
          end
          OP_ERASE: begin
            ram_we       = 1'b1;
            ram_wdata    = leaf_word & ~bit_mask;
            valid_d[w_q] = 1'b1;
            if ((leaf_word & ~bit_mask) == '0) begin
              summary_d[w_q] = 1'b0;
            end
            res_hit_d = leaf_word[off_q];
          end
          OP_CONTAINS: res_hit_d = leaf_word[off_q];
          OP_FIND_NEXT, OP_FIND_PREV: begin
            if (enc_hit) begin
              res_hit_d = srch_ok;
              res_pos_d = srch_ok ? srch_pos : n_eff;
            end
          end
          default: ;
        endcase
      end
      S_SUM: begin
        if (enc_hit) begin
          ram_raddr = enc_idx;
          rd_w_d    = enc_idx;
        end else begin
          res_hit_d = 1'b0;
          res_pos_d = n_eff;
        end
      end
      S_LEAF2: begin
        res_hit_d = srch_ok;
        res_pos_d = srch_ok ? srch_pos : n_eff;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SIZE_RESET;
      sent_q      <= SENT_RESET;
      summary_q   <= SUMMARY_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sent_q      <= sent_d;
      summary_q   <= summary_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        size_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    w_q       <= w_d;
    off_q     <= off_d;
    rd_w_q    <= rd_w_d;
    res_hit_q <= res_hit_d;
    res_bad_q <= res_bad_d;
    res_pos_q <= res_pos_d;
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_bad_q <= res_bad_q;
      out_pos_q <= res_pos_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.position  = out_pos_q;
  assign rsp_o.bad_index = out_bad_q;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !req_i.ready, "ready high after accept")
  `ASSERT_SAME(a_rsp_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE), "response not from done state")
  `ASSERT_SAME(a_bad_no_hit, clk_i, rst_ni, out_valid_q && out_bad_q, !out_hit_q, "hit on rejected request")
  `ASSERT_SAME(a_write_in_leaf, clk_i, rst_ni, ram_we, state_q == S_LEAF && (op_q == OP_INSERT || op_q == OP_ERASE), "leaf write outside update")

endmodule

`default_nettype wire

@@ tb/tb_hierarchical_bitset_successor.sv @@
// Testbench for the bitset block: random and directed requests checked against a tree predictor.
`timescale 1ns / 1ps

module tb_hierarchical_bitset_successor;
  import hbs_pkg::*;

  localparam int TREE_BITS   = WORD_BITS * LEAF_WORDS;
  localparam int SIZE_CAP    = TREE_BITS - 2;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 12;

  localparam logic [OPCODE_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    index;
  } bitset_req_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] position;
    logic             bad_index;
  } bitset_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  hbs_req_if req ();
  hbs_rsp_if rsp ();
  hbs_cfg_if cfg ();

  hierarchical_bitset_successor i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always #5 clk = ~clk;

  bitset_req_t request_q[$];
  bitset_rsp_t answer_q[$];

  logic [WORD_BITS-1:0]  leaf_bits[LEAF_WORDS];
  logic [LEAF_WORDS-1:0] word_busy;
  logic [IDX_W-1:0]      size_reg;

  int send_idle_pct;
  int recv_stall_pct;
  int holds_asked;
  int holds_served;
  int hold_left;
  int win_lo;
  int win_span;
  int errors;
  int accepted_count;
  int found_count;
  int cfg_writes;
  int cycle_count;

  function automatic int unsigned used_size();
    return (size_reg > SIZE_CAP) ? SIZE_CAP : size_reg;
  endfunction

  function automatic void mark_bit(int unsigned b);
    int unsigned w;
    w = (b / WORD_BITS) % LEAF_WORDS;
    leaf_bits[w][b % WORD_BITS] = 1'b1;
    word_busy[w] = 1'b1;
  endfunction

  function automatic void wipe_tree();
    for (int k = 0; k < LEAF_WORDS; k++) leaf_bits[k] = '0;
    word_busy = '0;
    mark_bit(0);
    mark_bit(used_size() + 1);
  endfunction

  function automatic int unsigned lowest_one(logic [WORD_BITS-1:0] v);
    for (int k = 0; k < WORD_BITS; k++) if (v[k]) return k;
    return WORD_BITS;
  endfunction

  function automatic int unsigned highest_one(logic [WORD_BITS-1:0] v);
    for (int k = WORD_BITS - 1; k >= 0; k--) if (v[k]) return k;
    return 0;
  endfunction

  // first set tree bit at or above b, TREE_BITS when none
  function automatic int unsigned bit_at_or_above(int unsigned b);
    int unsigned w, off;
    logic [WORD_BITS-1:0] m;
    w = b / WORD_BITS;
    off = b % WORD_BITS;
    m = leaf_bits[w] & ({WORD_BITS{1'b1}} << off);
    if (m != 0) return w * WORD_BITS + lowest_one(m);
    for (int w2 = w + 1; w2 < LEAF_WORDS; w2++)
      if (word_busy[w2] && leaf_bits[w2] != 0) return w2 * WORD_BITS + lowest_one(leaf_bits[w2]);
    return TREE_BITS;
  endfunction

  // last set tree bit at or below b, 0 when none
  function automatic int unsigned bit_at_or_below(int unsigned b);
    int unsigned w, off;
    logic [WORD_BITS-1:0] m;
    w = b / WORD_BITS;
    off = b % WORD_BITS;
    m = leaf_bits[w] & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - off));
    if (m != 0) return w * WORD_BITS + highest_one(m);
    for (int w2 = int'(w) - 1; w2 >= 0; w2--)
      if (word_busy[w2] && leaf_bits[w2] != 0) return w2 * WORD_BITS + highest_one(leaf_bits[w2]);
    return 0;
  endfunction

  function automatic bitset_rsp_t apply_set_op(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] idx);
    bitset_rsp_t r;
    int unsigned n, b, w, found;
    logic [WORD_BITS-1:0] mask;
    n = used_size();
    b = idx + 1;
    w = (b / WORD_BITS) % LEAF_WORDS;
    mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << (b % WORD_BITS);
    r.hit = 1'b0;
    r.position = idx;
    r.bad_index = 1'b0;
    case (op)
      OP_INSERT, OP_ERASE, OP_CONTAINS, OP_FIND_PREV: r.bad_index = (idx >= n);
      OP_FIND_NEXT: r.bad_index = (idx > n);
      OP_CLEAR: r.bad_index = 1'b0;
      default: r.bad_index = 1'b1;
    endcase
    if (!r.bad_index) begin
      case (op)
        OP_INSERT: begin
          if ((leaf_bits[w] & mask) == 0) begin
            leaf_bits[w] |= mask;
            word_busy[w] = 1'b1;
            r.hit = 1'b1;
          end
        end
        OP_ERASE: begin
          if ((leaf_bits[w] & mask) != 0) begin
            leaf_bits[w] &= ~mask;
            if (leaf_bits[w] == 0) word_busy[w] = 1'b0;
            r.hit = 1'b1;
          end
        end
        OP_CONTAINS: r.hit = ((leaf_bits[w] & mask) != 0);
        OP_FIND_NEXT: begin
          found = bit_at_or_above(b);
          if (found >= TREE_BITS || found - 1 >= n) begin
            r.position = IDX_W'(n);
          end else begin
            r.position = IDX_W'(found - 1);
            r.hit = 1'b1;
          end
        end
        OP_FIND_PREV: begin
          found = bit_at_or_below(b);
          if (found == 0) begin
            r.position = IDX_W'(n);
          end else begin
            r.position = IDX_W'(found - 1);
            r.hit = 1'b1;
          end
        end
        OP_CLEAR: wipe_tree();
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned n, r, v;
    n = used_size();
    r = $urandom_range(99);
    if (r < 60) begin
      v = win_lo + $urandom_range(win_span);
    end else if (r < 75) begin
      v = ((n >= 3) ? n - 3 : 0) + $urandom_range(4);
    end else if (r < 88) begin
      v = $urandom_range(LEAF_WORDS - 1) * WORD_BITS + $urandom_range(2);
      if (v != 0) v = v - 1;
    end else begin
      v = $urandom_range(SIZE_CAP);
    end
    if (v > SIZE_CAP) v = SIZE_CAP;
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(999);
    if (r < 300) return OP_INSERT;
    if (r < 470) return OP_ERASE;
    if (r < 590) return OP_CONTAINS;
    if (r < 770) return OP_FIND_NEXT;
    if (r < 950) return OP_FIND_PREV;
    if (r < 980) return OP_CLEAR;
    return $urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B;
  endfunction

  function automatic void queue_item(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] idx);
    request_q = {request_q, bitset_req_t'{opcode: op, index: idx}};
  endfunction

  function automatic void queue_random(int count);
    for (int i = 0; i < count; i++) queue_item(pick_opcode(), pick_index());
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || req.valid || answer_q.size() != 0);
  endtask

  task automatic write_size(input logic [IDX_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk);
    while (!cfg.ready);
    size_reg = value;
    cfg_writes++;
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(int span);
    int unsigned n;
    n = used_size();
    win_span = (span > n) ? n : span;
    win_lo = $urandom_range(n - win_span);
  endtask

  // request driver: predicts on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin : accept_blk
        bitset_rsp_t predicted;
        predicted = apply_set_op(req.opcode, req.index);
        answer_q = {answer_q, predicted};
        accepted_count++;
        if (predicted.hit && (req.opcode == OP_FIND_NEXT || req.opcode == OP_FIND_PREV))
          found_count++;
      end
      if (!req.valid || req.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req.valid  <= 1'b1;
          req.opcode <= request_q[0].opcode;
          req.index  <= request_q[0].index;
          void'(request_q.pop_front());
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin : check_blk
        bitset_rsp_t want;
        if (answer_q.size() == 0) begin
          $error("unexpected transaction: hit %0d position %0d bad_index %0d",
                 rsp.hit, rsp.position, rsp.bad_index);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            errors++;
          end
          if (rsp.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp.position);
            errors++;
          end
          if (rsp.bad_index !== want.bad_index) begin
            $error("bad_index: expected %0d, got %0d", want.bad_index, rsp.bad_index);
            errors++;
          end
        end
      end
      rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, answer_q.size());
    $display("[hierarchical_bitset_successor] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.opcode = OP_INSERT;
    req.index = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cycle_count = 0;
    errors = 0;
    accepted_count = 0;
    found_count = 0;
    cfg_writes = 0;
    holds_asked = 0;
    send_idle_pct = 11;
    recv_stall_pct = 82;
    win_lo = 0;
    win_span = 0;
    size_reg = SIZE_RESET;
    wipe_tree();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size, sentinels at both ends
    queue_item(OP_CONTAINS, 0);
    queue_item(OP_INSERT, 0);
    queue_item(OP_INSERT, 0);
    queue_item(OP_FIND_PREV, 0);
    queue_item(OP_INSERT, IDX_W'(SIZE_CAP - 1));
    queue_item(OP_FIND_NEXT, IDX_W'(SIZE_CAP));
    queue_item(OP_FIND_NEXT, 1);
    queue_item(OP_INSERT, IDX_W'(WORD_BITS - 2));
    queue_item(OP_INSERT, IDX_W'(WORD_BITS - 1));
    queue_item(OP_FIND_NEXT, 0);
    queue_item(OP_ERASE, 0);
    queue_item(OP_ERASE, 0);
    queue_item(OP_FIND_PREV, IDX_W'(WORD_BITS - 3));
    queue_item(OP_FIND_PREV, IDX_W'(SIZE_CAP - 1));
    queue_item(OP_INSERT, IDX_W'(SIZE_CAP));
    queue_item(OP_FIND_PREV, IDX_W'(SIZE_CAP));
    queue_item(OP_UNDEF_A, IDX_W'(SIZE_CAP));
    queue_item(OP_UNDEF_B, 0);
    queue_item(OP_CLEAR, 0);
    queue_item(OP_FIND_NEXT, 0);
    wait_idle();

    // smallest size, no clear: stale tree bits
    write_size(1);
    queue_item(OP_FIND_NEXT, 0);
    queue_item(OP_INSERT, 0);
    queue_item(OP_FIND_NEXT, 1);
    queue_item(OP_FIND_PREV, 0);
    queue_item(OP_CONTAINS, 1);
    queue_item(OP_CLEAR, 0);
    queue_item(OP_FIND_NEXT, 1);
    wait_idle();

    write_size(IDX_W'($urandom_range(700, 100)));
    set_window(160);
    queue_item(OP_CLEAR, 0);
    queue_random(240);
    wait_idle();

    send_idle_pct = 82;
    recv_stall_pct = 11;
    write_size(IDX_W'(WORD_BITS - 2));
    set_window(WORD_BITS);
    queue_random(200);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_size(IDX_W'(SIZE_CAP));
    set_window(150);
    queue_item(OP_CLEAR, 0);
    queue_random(130);
    holds_asked++;
    wait_idle();
    set_window(150);
    queue_random(130);
    wait_idle();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d expected transactions never arrived", answer_q.size());
      errors++;
    end
    $display("%0d requests checked across %0d size settings, %0d searches found a member",
             accepted_count, cfg_writes, found_count);
    $display("stale-bit sizes, word-edge indexes and a %0d-cycle receiver hold-off included",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("[hierarchical_bitset_successor] OK");
    end else begin
      $display("[hierarchical_bitset_successor] ERROR");
    end
    $finish;
  end

endmodule
